>>> hdl/tga_rle_pixel_decoder_defines.svh
// Assertion macros for the run-length pixel decoder.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// Checked only outside reset.
`define TRPD_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");

// Checked on every edge.
`define TRPD_ASSERT_ALL(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

>>> hdl/trpd_pkg.sv
`default_nettype none
package trpd_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_RLE_ENABLE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_PIXELS    = 2'd2;

   localparam logic [7:0] HDR_LEN_MASK   = 8'h7F;
   localparam logic [7:0] HDR_REPEAT_BIT = 8'h80;
   localparam logic [2:0] BPP_WIDE       = 3'd4;
   localparam logic [2:0] BPP_RESET      = 3'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_image;
      logic       hdr_repeat;
      logic [7:0] hdr_run_len;
   } req_item_type;

   typedef struct packed {
      logic [31:0] pixel_value;
      logic [7:0]  repeat_count;
      logic        image_done;
   } rsp_item_type;

   typedef struct packed {
      logic        rle_enable;
      logic [2:0]  bytes_per_pixel;
      logic [31:0] total_pixels;
   } cfg_type;

endpackage
`default_nettype wire

>>> hdl/trpd_front.sv
`default_nettype none
module trpd_front #(
   parameter int DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  first_of_image,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       item_valid,
   output trpd_pkg::req_item_type     item
);
   import trpd_pkg::*;
   `include "tga_rle_pixel_decoder_defines.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   req_item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   req_item_type           classified;
   logic                   do_push, do_pop;

   // header fields are split off on entry
   always_comb begin
      classified.data_byte      = data_byte;
      classified.first_of_image = first_of_image;
      classified.hdr_repeat     = |(data_byte & HDR_REPEAT_BIT);
      classified.hdr_run_len    = (data_byte & HDR_LEN_MASK) + 8'd1;
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

   `TRPD_ASSERT_RST(a_front_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

>>> hdl/trpd_back.sv
`default_nettype none
module trpd_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire trpd_pkg::cfg_type     cfg,
   input  wire logic                  item_valid,
   input  wire trpd_pkg::req_item_type item,
   output logic                       item_pop,
   input  wire logic                  rsp_full,
   output logic                       rsp_push,
   output trpd_pkg::rsp_item_type     rsp_item
);
   import trpd_pkg::*;
   `include "tga_rle_pixel_decoder_defines.svh"

   logic [31:0] pix_left_ff, pix_left_in;
   logic [7:0]  run_left_ff, run_left_in;
   logic        run_rep_ff, run_rep_in;
   logic [1:0]  byte_pos_ff, byte_pos_in;
   logic [31:0] assembly_ff, assembly_in;

   logic [31:0] pix_left_e;
   logic [7:0]  run_left_e;
   logic        run_rep_e;
   logic [1:0]  byte_pos_e;
   logic [31:0] assembly_e;
   logic [31:0] assembly_n;
   logic [1:0]  last_pos;
   logic [7:0]  count;
   logic        fire;

   assign item_pop = item_valid && !rsp_full;
   assign fire     = item_pop;
   assign last_pos = (cfg.bytes_per_pixel == BPP_WIDE) ? 2'd3 : 2'd2;

   always_comb begin
      pix_left_e = pix_left_ff;
      run_left_e = run_left_ff;
      run_rep_e  = run_rep_ff;
      byte_pos_e = byte_pos_ff;
      assembly_e = assembly_ff;
      if (item.first_of_image) begin
         pix_left_e = cfg.total_pixels;
         run_left_e = '0;
         run_rep_e  = 1'b0;
         byte_pos_e = '0;
         assembly_e = '0;
      end

      pix_left_in = pix_left_e;
      run_left_in = run_left_e;
      run_rep_in  = run_rep_e;
      byte_pos_in = byte_pos_e;
      assembly_in = assembly_e;
      rsp_push    = 1'b0;
      count       = 8'd1;
      assembly_n  = (byte_pos_e == 2'd0) ? '0 : assembly_e;
      assembly_n[8*byte_pos_e +: 8] = item.data_byte;

      if (pix_left_e == '0) begin
         // idle: byte dropped
      end else if (cfg.rle_enable && run_left_e == '0) begin
         run_left_in = item.hdr_run_len;
         run_rep_in  = item.hdr_repeat;
         byte_pos_in = '0;
         assembly_in = '0;
      end else begin
         assembly_in = assembly_n;
         if (byte_pos_e < last_pos) begin
            byte_pos_in = byte_pos_e + 2'd1;
         end else begin
            byte_pos_in = '0;
            rsp_push    = 1'b1;
            if (cfg.rle_enable && run_rep_e) begin
               count       = ({24'd0, run_left_e} > pix_left_e) ? pix_left_e[7:0]
                                                                 : run_left_e;
               run_left_in = '0;
            end else if (cfg.rle_enable && run_left_e != '0) begin
               run_left_in = run_left_e - 8'd1;
            end
            pix_left_in = pix_left_e - {24'd0, count};
            if (pix_left_in == '0) begin
               run_left_in = '0;
               run_rep_in  = 1'b0;
            end
         end
      end
      rsp_push = rsp_push && fire;

      rsp_item.pixel_value  = assembly_n;
      rsp_item.repeat_count = count;
      rsp_item.image_done   = (pix_left_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_left_ff <= '0;
         run_left_ff <= '0;
         run_rep_ff  <= 1'b0;
         byte_pos_ff <= '0;
         assembly_ff <= '0;
      end else if (fire) begin
         pix_left_ff <= pix_left_in;
         run_left_ff <= run_left_in;
         run_rep_ff  <= run_rep_in;
         byte_pos_ff <= byte_pos_in;
         assembly_ff <= assembly_in;
      end
   end

   `TRPD_ASSERT_RST(a_back_done_clears, clock, reset,
      rsp_push && rsp_item.image_done |=> pix_left_ff == '0 && run_left_ff == '0)
   `TRPD_ASSERT_RST(a_back_count_nonzero, clock, reset, rsp_push |-> rsp_item.repeat_count != 8'd0)

endmodule
`default_nettype wire

>>> hdl/trpd_rsp_queue.sv
`default_nettype none
module trpd_rsp_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire trpd_pkg::rsp_item_type push_item,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       empty,
   output trpd_pkg::rsp_item_type     head
);
   import trpd_pkg::*;
   `include "tga_rle_pixel_decoder_defines.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `TRPD_ASSERT_RST(a_rsp_fill, clock, reset, do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)

endmodule
`default_nettype wire

>>> hdl/tga_rle_pixel_decoder.sv
// Channel   Ports                                   Handshake
// req       req_data_byte, req_first_of_image       req_push & !req_full
// rsp       rsp_pixel_value, rsp_repeat_count,      rsp_pop & !rsp_empty
//           rsp_image_done
// csr       csr_index, csr_wdata                    csr_write
//
// While the rsp queue is not full, one byte item per cycle is sustained and the decoder stage retires one item a cycle.
// An accepted byte is held in the req queue; the pixel it completes is registered in the rsp queue before rsp shows it.
// Synchronous active-high reset clears queues and decoder state; csr regs reset
// to rle off, 3 bytes per pixel, 1 pixel.
// A full rsp queue stalls the decoder; the req queue then fills and raises req_full.
`default_nettype none
module tga_rle_pixel_decoder #(
   parameter int REQ_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [7:0]                           req_data_byte,
   input  wire logic                                 req_first_of_image,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic [31:0]                               rsp_pixel_value,
   output logic [7:0]                                rsp_repeat_count,
   output logic                                      rsp_image_done,
   input  wire logic                                 csr_write,
   input  wire logic [trpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [trpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import trpd_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   req_item_type front_item;
   logic         front_valid, front_pop;
   rsp_item_type back_item, rsp_head;
   logic         back_push, rsp_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_RLE_ENABLE:      cfg_in.rle_enable      = csr_wdata[0];
            CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_wdata[2:0];
            CSR_TOTAL_PIXELS:    cfg_in.total_pixels    = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rle_enable      <= 1'b0;
         cfg_ff.bytes_per_pixel <= BPP_RESET;
         cfg_ff.total_pixels    <= 32'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   trpd_front #(
      .DEPTH(REQ_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (req_push),
      .data_byte      (req_data_byte),
      .first_of_image (req_first_of_image),
      .full           (req_full),
      .pop            (front_pop),
      .item_valid     (front_valid),
      .item           (front_item)
   );

   trpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (front_valid),
      .item       (front_item),
      .item_pop   (front_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (back_push),
      .rsp_item   (back_item)
   );

   trpd_rsp_queue #(
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_item (back_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_pixel_value  = rsp_head.pixel_value;
   assign rsp_repeat_count = rsp_head.repeat_count;
   assign rsp_image_done   = rsp_head.image_done;

endmodule
`default_nettype wire

>>> tb/pixel_stream_checker.sv
`timescale 1ns / 100ps
module pixel_stream_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic                             req_full,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_first_of_image,
   input  logic                             rsp_empty,
   input  logic                             rsp_pop,
   input  logic [31:0]                      rsp_pixel_value,
   input  logic [7:0]                       rsp_repeat_count,
   input  logic                             rsp_image_done,
   input  logic                             csr_write,
   input  logic [trpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [trpd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               fail_count,
   output int                               pending
);
   import trpd_pkg::*;

   cfg_type      cfg;
   logic [31:0]  pixels_left;
   logic [7:0]   run_left;
   logic         run_repeat;
   logic [1:0]   byte_pos;
   logic [31:0]  pixel_acc;
   rsp_item_type expected_pixels[$];
   int           mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 100) begin
         $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic first);
      rsp_item_type pix;
      logic [31:0]  count;
      logic [1:0]   last_pos;
      if (first) begin
         pixels_left = cfg.total_pixels;
         run_left    = '0;
         run_repeat  = 1'b0;
         byte_pos    = '0;
         pixel_acc   = '0;
      end
      if (pixels_left == 0) return;
      // packet header
      if (cfg.rle_enable && run_left == 0) begin
         run_left   = (b & HDR_LEN_MASK) + 8'd1;
         run_repeat = |(b & HDR_REPEAT_BIT);
         byte_pos   = '0;
         pixel_acc  = '0;
         return;
      end
      if (byte_pos == 0) pixel_acc = '0;
      pixel_acc = pixel_acc | (32'(b) << (8 * byte_pos));
      last_pos = (cfg.bytes_per_pixel == BPP_WIDE) ? 2'd3 : 2'd2;
      if (byte_pos < last_pos) begin
         byte_pos++;
         return;
      end
      byte_pos = '0;
      if (cfg.rle_enable && run_repeat) begin
         count    = (32'(run_left) > pixels_left) ? pixels_left : 32'(run_left);
         run_left = '0;
      end else begin
         count = 32'd1;
         if (cfg.rle_enable && run_left != 0) run_left--;
      end
      pixels_left -= count;
      if (pixels_left == 0) begin
         run_left   = '0;
         run_repeat = 1'b0;
      end
      pix.pixel_value  = pixel_acc;
      pix.repeat_count = count[7:0];
      pix.image_done   = (pixels_left == 0);
      expected_pixels.push_back(pix);
   endtask

   always @(posedge clock) begin : watch
      rsp_item_type head;
      if (reset) begin
         cfg.rle_enable      = 1'b0;
         cfg.bytes_per_pixel = BPP_RESET;
         cfg.total_pixels    = 32'd1;
         pixels_left         = '0;
         run_left            = '0;
         run_repeat          = 1'b0;
         byte_pos            = '0;
         pixel_acc           = '0;
         expected_pixels.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("result with nothing expected, pixel_value",
                               rsp_pixel_value, '0);
            end else begin
               head = expected_pixels.pop_front();
               if (rsp_pixel_value !== head.pixel_value)
                  report_mismatch("pixel_value", rsp_pixel_value, head.pixel_value);
               if (rsp_repeat_count !== head.repeat_count)
                  report_mismatch("repeat_count", 32'(rsp_repeat_count),
                                  32'(head.repeat_count));
               if (rsp_image_done !== head.image_done)
                  report_mismatch("image_done", 32'(rsp_image_done),
                                  32'(head.image_done));
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_RLE_ENABLE:      cfg.rle_enable      = csr_wdata[0];
               CSR_BYTES_PER_PIXEL: cfg.bytes_per_pixel = csr_wdata[2:0];
               CSR_TOTAL_PIXELS:    cfg.total_pixels    = csr_wdata[31:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) decode_byte(req_data_byte, req_first_of_image);
      end
      pending <= expected_pixels.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
   import trpd_pkg::*;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   req_push           = 1'b0;
   logic                   req_full;
   logic [7:0]             req_data_byte      = '0;
   logic                   req_first_of_image = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop            = 1'b0;
   logic [31:0]            rsp_pixel_value;
   logic [7:0]             rsp_repeat_count;
   logic                   rsp_image_done;
   logic                   csr_write          = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata          = '0;

   int          fail_count;
   int          pending;
   int          bytes_sent   = 0;
   bit          no_idle      = 1'b0;
   bit          hold_request = 1'b0;
   bit          mark_first   = 1'b0;
   logic        rle_on       = 1'b0;
   logic [2:0]  bpp_reg      = BPP_RESET;
   logic [31:0] pixel_total  = 32'd1;

   always #6 clock = ~clock;

   tga_rle_pixel_decoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_first_of_image (req_first_of_image),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_repeat_count   (rsp_repeat_count),
      .rsp_image_done     (rsp_image_done),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   pixel_stream_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_first_of_image (req_first_of_image),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_repeat_count   (rsp_repeat_count),
      .rsp_image_done     (rsp_image_done),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

   // result side: random stalls, one long hold on request
   initial begin : pixel_sink
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (hold_request) begin
            hold_request = 1'b0;
            stall = 80;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   task automatic push_byte(input logic [7:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push           <= 1'b1;
      req_data_byte      <= value;
      req_first_of_image <= mark_first;
      mark_first = 1'b0;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic configure(input logic rle, input logic [2:0] bpp,
                            input logic [31:0] total, input logic [2:0] sel);
      if (sel[0]) begin
         csr_write <= 1'b1;
         csr_index <= CSR_RLE_ENABLE;
         csr_wdata <= {31'd0, rle};
         rle_on = rle;
         @(posedge clock);
      end
      if (sel[1]) begin
         csr_write <= 1'b1;
         csr_index <= CSR_BYTES_PER_PIXEL;
         csr_wdata <= {29'd0, bpp};
         bpp_reg = bpp;
         @(posedge clock);
      end
      if (sel[2]) begin
         csr_write <= 1'b1;
         csr_index <= CSR_TOTAL_PIXELS;
         csr_wdata <= total;
         pixel_total = total;
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // well-formed image for the settings, cut at a run end once byte_cap is met
   task automatic send_image(input int byte_cap);
      int   start_count;
      int   covered;
      int   len;
      int   pixels;
      int   width;
      logic repeat_run;
      start_count = bytes_sent;
      covered     = 0;
      width       = (bpp_reg == BPP_WIDE) ? 4 : 3;
      mark_first  = 1'b1;
      while (covered < pixel_total && bytes_sent - start_count < byte_cap) begin
         if (rle_on) begin
            repeat_run = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0 && (repeat_run || $urandom_range(0, 3) == 0))
               len = $urandom_range(0, 127);
            else
               len = $urandom_range(0, 7);
            push_byte({repeat_run, 7'(len)});
            covered += len + 1;
            pixels = repeat_run ? 1 : len + 1;
         end else begin
            covered += 1;
            pixels = 1;
         end
         repeat (pixels * width) push_byte(8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      int          phase;
      int          images;
      int          r;
      logic        rle;
      logic [2:0]  bpp;
      logic [31:0] total;
      logic [2:0]  sel;
      bit          resume_image;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: plain, 3 bytes, 1 pixel; trailing byte ignored
      mark_first = 1'b1;
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h80);
      push_byte(8'hAA);
      drain();

      // longest repeat run cut to the pixels left
      configure(1'b1, BPP_WIDE, 32'd3, 3'b111);
      mark_first = 1'b1;
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h7F);
      push_byte(8'h80);
      drain();

      // literal run past the end of the image
      configure(1'b1, BPP_RESET, 32'd2, 3'b111);
      mark_first = 1'b1;
      push_byte(8'h04);
      for (int i = 0; i < 8; i++) push_byte(8'(8'h11 * (i + 1)));
      drain();

      // empty image, odd pixel width code
      configure(1'b0, 3'd7, 32'd0, 3'b111);
      mark_first = 1'b1;
      push_byte(8'h12);
      drain();

      // largest image, left mid-pixel for the next settings
      configure(1'b0, BPP_WIDE, 32'hFFFF_FFFF, 3'b111);
      mark_first = 1'b1;
      push_byte(8'h01);
      push_byte(8'h02);
      push_byte(8'h03);
      push_byte(8'h04);
      push_byte(8'h05);
      drain();

      phase = 0;
      while (bytes_sent < 1800) begin
         phase++;
         no_idle = ($urandom_range(0, 3) == 0);
         rle = 1'($urandom_range(0, 1));
         r = $urandom_range(0, 9);
         bpp = (r < 5) ? BPP_WIDE : (r < 9) ? BPP_RESET : 3'($urandom_range(0, 7));
         r = $urandom_range(0, 19);
         case (r)
            0:       total = 32'd0;
            1:       total = 32'hFFFF_FFFF;
            2:       total = $urandom;
            3, 4, 5: total = $urandom_range(100, 300);
            default: total = $urandom_range(1, 16);
         endcase
         sel = 3'($urandom_range(0, 7));
         resume_image = ($urandom_range(0, 3) == 0);
         if (phase == 3 || phase == 30) begin
            // back up the result queue so the input side stalls
            rle = 1'b0;
            bpp = BPP_RESET;
            total = 32'hFFFF_FFFF;
            sel = 3'b111;
            resume_image = 1'b0;
            no_idle = 1'b1;
            hold_request = 1'b1;
         end
         configure(rle, bpp, total, sel);
         if (resume_image) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
         end
         images = $urandom_range(1, 3);
         repeat (images) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 12)) begin
                  mark_first = ($urandom_range(0, 7) == 0);
                  push_byte(8'($urandom_range(0, 255)));
               end
            end else begin
               send_image(60);
            end
         end
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/trpd_pkg.sv
hdl/trpd_front.sv
hdl/trpd_back.sv
hdl/trpd_rsp_queue.sv
hdl/tga_rle_pixel_decoder.sv
tb/pixel_stream_checker.sv
tb/testbench.sv
